FILE: hw/rtl/sts_pkg.sv
// Shared types and codes for the sorted table search block.
package sts_pkg;

    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int MODE_W  = 2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic CFG_ENTRY_COUNT = 1'b0;
    localparam logic CFG_SEARCH_MODE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_FORWARD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BACKWARD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BINARY   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1;

    typedef struct packed {
        logic                      command;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [VALUE_W-1:0] item_value;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] position;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_STORE,
        OP_SKIP,
        OP_SEARCH
    } op_kind_t;

    typedef struct packed {
        op_kind_t           op;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } op_entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_CHECK
    } back_state_t;

    // flips the sign bit so unsigned compare follows signed order
    function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] v);
        order_key = v ^ {1'b1, {(VALUE_W-1){1'b0}}};
    endfunction

endpackage

FILE: hw/rtl/sts_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module sts_front #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sts_pkg::in_item_t in_item,
    output logic              q_valid,
    input  logic              q_pop,
    output sts_pkg::op_entry_t q_head
);
    import sts_pkg::*;

    op_entry_t  slot_reg [2];
    op_entry_t  decoded;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    logic       in_range;

    assign in_range = 32'(in_item.entry_index) < 32'(TABLE_DEPTH);

    always_comb
    begin
        decoded.index = in_item.entry_index;
        decoded.value = in_item.item_value;
        unique case (in_item.command)
            CMD_WRITE:  decoded.op = in_range ? OP_STORE : OP_SKIP;
            CMD_SEARCH: decoded.op = OP_SEARCH;
            default:    decoded.op = OP_SKIP;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_head   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

FILE: hw/rtl/sts_back.sv
// Back end: table memory, search sequencer and result register.
module sts_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    output logic                                q_pop,
    input  sts_pkg::op_entry_t                  q_head,
    input  logic [sts_pkg::COUNT_W-1:0]         entry_count,
    input  logic [sts_pkg::MODE_W-1:0]          search_mode,
    output logic                                out_valid,
    input  logic                                out_ready,
    output sts_pkg::out_item_t                  out_item
);
    import sts_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [VALUE_W-1:0] table_mem [TABLE_DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    back_state_t        state_reg, state_next;
    logic [COUNT_W-1:0] probe_reg, probe_next;
    logic signed [COUNT_W:0] lo_reg, lo_next;
    logic signed [COUNT_W:0] hi_reg, hi_next;
    logic [VALUE_W-1:0] key_reg, key_next;
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    logic               wr_en;
    logic               rd_en;
    logic [COUNT_W-1:0] rd_idx;
    logic               out_load;
    out_item_t          out_item_d;
    logic               out_free;
    logic [COUNT_W-1:0] n_used;
    logic [COUNT_W-1:0] n_m1;
    logic               is_fwd;
    logic               is_bwd;
    logic               match;
    logic               key_gt;
    logic               key_lt;
    logic               hit;
    logic               miss;
    logic [COUNT_W-1:0] step_idx;
    logic signed [COUNT_W:0] lo_bin, hi_bin;
    logic signed [COUNT_W:0] probe_s;
    logic [COUNT_W+1:0] mid_sum;

    assign n_used   = (32'(entry_count) > 32'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH)
                                                             : entry_count;
    assign n_m1     = n_used - 11'd1;
    assign out_free = !out_valid_reg || out_ready;
    assign is_fwd   = (search_mode == MODE_FORWARD);
    assign is_bwd   = (search_mode == MODE_BACKWARD);

    assign match   = (rd_data_reg == key_reg);
    assign key_gt  = order_key(key_reg) > order_key(rd_data_reg);
    assign key_lt  = order_key(key_reg) < order_key(rd_data_reg);
    assign probe_s = $signed({1'b0, probe_reg});
    assign lo_bin  = key_gt ? probe_s + 12'sd1 : lo_reg;
    assign hi_bin  = key_lt ? probe_s - 12'sd1 : hi_reg;
    assign mid_sum = {lo_bin[COUNT_W], lo_bin} + {hi_bin[COUNT_W], hi_bin};

    always_comb
    begin
        state_next = state_reg;
        probe_next = probe_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        key_next   = key_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_idx     = probe_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        out_item_d = '0;
        hit        = 1'b0;
        miss       = 1'b0;
        step_idx   = probe_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_head.op)
                        OP_STORE:
                        begin
                            wr_en = 1'b1;
                            q_pop = 1'b1;
                        end
                        OP_SKIP:
                        begin
                            q_pop = 1'b1;
                        end
                        OP_SEARCH:
                        begin
                            if (n_used == '0)
                            begin
                                if (out_free)
                                begin
                                    out_load = 1'b1;
                                    q_pop    = 1'b1;
                                end
                            end
                            else
                            begin
                                q_pop    = 1'b1;
                                key_next = q_head.value;
                                lo_next  = 12'sd0;
                                hi_next  = $signed({1'b0, n_m1});
                                case (search_mode)
                                    MODE_FORWARD:  step_idx = '0;
                                    MODE_BACKWARD: step_idx = n_m1;
                                    default:       step_idx = {1'b0, n_m1[COUNT_W-1:1]};
                                endcase
                                rd_en      = 1'b1;
                                rd_idx     = step_idx;
                                probe_next = step_idx;
                                state_next = ST_CHECK;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (match)
                begin
                    hit = 1'b1;
                end
                else if (is_fwd)
                begin
                    miss     = (probe_reg + 11'd1 == n_used);
                    step_idx = probe_reg + 11'd1;
                end
                else if (is_bwd)
                begin
                    miss     = (probe_reg == '0);
                    step_idx = probe_reg - 11'd1;
                end
                else
                begin
                    miss     = (lo_bin > hi_bin);
                    step_idx = mid_sum[COUNT_W:1];
                end

                if (hit || miss)
                begin
                    if (out_free)
                    begin
                        out_load            = 1'b1;
                        out_item_d.found    = hit;
                        out_item_d.position = hit ? probe_reg + 11'd1 : '0;
                        state_next          = ST_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_idx     = step_idx;
                    probe_next = step_idx;
                    lo_next    = lo_bin;
                    hi_next    = hi_bin;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        key_reg   <= key_next;
        if (out_load)
        begin
            out_item_reg <= out_item_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[AW'(q_head.index)] <= q_head.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[AW'(rd_idx)];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.found == (out_item_reg.position != '0)))
        else $error("found flag disagrees with position");

    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> probe_reg < n_used)
        else $error("probe index beyond used entries");

    a_bin_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && !is_fwd && !is_bwd) |->
            (lo_reg <= probe_s && probe_s <= hi_reg))
        else $error("bisection probe outside window");

    a_read_check: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> state_reg == ST_CHECK)
        else $error("memory read without a check cycle");

    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result overwrites a pending one");

endmodule

FILE: hw/rtl/sorted_table_search.sv
// Top level of the sorted table search block: config registers, front and back ends.
// Write request: written to the table once it reaches the queue head with the back end idle.
// Search request: P probes, one table read each, then the result is loaded into the output register.
// P is up to min(entry_count, TABLE_DEPTH) in linear modes, up to floor(log2(that))+1 in binary mode.
// One table read per cycle from the single-port memory sets the probe rate.
// Reset clears control and queue; entry_count=1, search_mode=2; table undefined until written.
module sorted_table_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  sts_pkg::in_item_t            in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output sts_pkg::out_item_t           out_item,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [sts_pkg::COUNT_W-1:0]  cfg_data
);
    import sts_pkg::*;

    logic [COUNT_W-1:0] entry_count_reg;
    logic [MODE_W-1:0]  search_mode_reg;
    logic               q_valid;
    logic               q_pop;
    op_entry_t          q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= COUNT_RESET;
            search_mode_reg <= MODE_BINARY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENTRY_COUNT: entry_count_reg <= cfg_data;
                CFG_SEARCH_MODE: search_mode_reg <= cfg_data[MODE_W-1:0];
                default:         ;
            endcase
        end
    end

    sts_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_head   (q_head)
    );

    sts_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_head      (q_head),
        .entry_count (entry_count_reg),
        .search_mode (search_mode_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

endmodule

FILE: verif/sorted_table_search_tb.sv
// Self-checking testbench for sorted_table_search: table loads, searches in every mode, stalls.

class search_scoreboard;
    localparam int DEPTH = 256;

    logic [31:0]                  tbl [DEPTH];
    logic [sts_pkg::COUNT_W-1:0]  count;
    logic [sts_pkg::MODE_W-1:0]   mode;
    sts_pkg::out_item_t           expected_q [$];
    int                           errors;

    function new();
        count  = sts_pkg::COUNT_RESET;
        mode   = sts_pkg::MODE_BINARY;
        errors = 0;
        foreach (tbl[i])
            tbl[i] = '0;
    endfunction

    function void set_register(logic idx, logic [sts_pkg::COUNT_W-1:0] data);
        if (idx == sts_pkg::CFG_ENTRY_COUNT)
            count = data;
        else
            mode = data[sts_pkg::MODE_W-1:0];
    endfunction

    // 1-based position of the match, 0 when absent
    function logic [sts_pkg::COUNT_W-1:0] locate(logic [31:0] key);
        int n;
        int lo;
        int hi;
        int mid;
        int pos;
        n = (count > DEPTH) ? DEPTH : int'(count);
        pos = 0;
        if (n != 0)
        begin
            case (mode)
                sts_pkg::MODE_FORWARD:
                begin
                    for (int i = 0; i < n && pos == 0; i++)
                        if (tbl[i] == key)
                            pos = i + 1;
                end
                sts_pkg::MODE_BACKWARD:
                begin
                    for (int i = n; i > 0 && pos == 0; i--)
                        if (tbl[i-1] == key)
                            pos = i;
                end
                default:
                begin
                    lo = 0;
                    hi = n - 1;
                    while (lo <= hi && pos == 0)
                    begin
                        mid = (lo + hi) / 2;
                        if ($signed(key) > $signed(tbl[mid]))
                            lo = mid + 1;
                        else if ($signed(key) < $signed(tbl[mid]))
                            hi = mid - 1;
                        else
                            pos = mid + 1;
                    end
                end
            endcase
        end
        return pos[sts_pkg::COUNT_W-1:0];
    endfunction

    function void note_request(sts_pkg::in_item_t it);
        sts_pkg::out_item_t e;
        if (it.command == sts_pkg::CMD_WRITE)
        begin
            if (it.entry_index < DEPTH)
                tbl[it.entry_index] = it.item_value;
        end
        else
        begin
            e.position = locate(it.item_value);
            e.found    = (e.position != 0);
            expected_q.push_back(e);
        end
    endfunction

    function void check_result(sts_pkg::out_item_t got);
        sts_pkg::out_item_t e;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none actual found %0b position %0d",
                     $time, got.found, got.position);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (got.found !== e.found)
        begin
            $display("%0t: found mismatch, expected %0b actual %0b", $time, e.found, got.found);
            errors++;
        end
        if (got.position !== e.position)
        begin
            $display("%0t: position mismatch, expected %0d actual %0d",
                     $time, e.position, got.position);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module sorted_table_search_tb;
    import sts_pkg::*;

    localparam int          DEPTH        = 256;
    localparam int          CYCLE_LIMIT  = 2_000_000;
    localparam int          SETTLE       = 20;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          RANDOM_ITEMS = 400;
    localparam logic [31:0] WORD_MIN     = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX     = 32'h7FFF_FFFF;
    localparam longint      VALUE_MIN    = -64'sd2147483648;
    localparam longint      VALUE_MAX    = 64'sd2147483647;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_item;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_item;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [COUNT_W-1:0] cfg_data;

    search_scoreboard   sb;
    logic [31:0]        shadow [DEPTH];
    bit                 quiet;
    bit                 hold_req;
    bit                 pressured;
    int                 cycles;
    int                 sent;
    int                 goal;
    int                 busy;
    int                 count_sel;
    int                 cnt_eff;
    int                 len;
    int                 r;
    int                 idx;
    logic [MODE_W-1:0]  mode_sel;
    logic [31:0]        key;
    longint             v;
    longint             lo_v;
    longint             hi_v;

    sorted_table_search #(.TABLE_DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.note_request(in_item);
        if (out_valid && out_ready)
            sb.check_result(out_item);
        if (cfg_valid && cfg_ready)
            sb.set_register(cfg_index, cfg_data);
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return $urandom_range(1, 3);
        else if (p < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    initial
    begin
        out_ready = 1'b0;
        busy      = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else if (busy > 0)
            begin
                busy--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < 25)
            begin
                busy = gap_len() - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic offer_request(input logic cmd, input int index, input logic [31:0] val);
        in_item_t it;
        int       gap;
        it.command     = cmd;
        it.entry_index = index[INDEX_W-1:0];
        it.item_value  = val;
        gap = (!quiet && $urandom_range(0, 99) < 35) ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        if (cmd == CMD_WRITE && index < DEPTH)
            shadow[index] = val;
        sent++;
    endtask

    task automatic store_entry(input int index, input logic [31:0] val);
        offer_request(CMD_WRITE, index, val);
    endtask

    task automatic search_for(input logic [31:0] val);
        offer_request(CMD_SEARCH, $urandom_range(0, DEPTH - 1), val);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(input logic index, input logic [COUNT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_mode(input logic [MODE_W-1:0] m);
        logic [8:0] upper;
        upper = 9'($urandom);
        write_register(CFG_SEARCH_MODE, {upper, m});
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ENTRY_COUNT;
        cfg_data  = '0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        pressured = 1'b0;
        sent      = 0;
        foreach (shadow[i])
            shadow[i] = '0;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, zero count, duplicates, every mode, unordered table
        store_entry(0, WORD_MIN);
        search_for(WORD_MIN);
        search_for(WORD_MAX);
        wait_idle();
        write_register(CFG_ENTRY_COUNT, '0);
        search_for(WORD_MIN);
        store_entry(1, 32'hFFFF_FFFB);
        store_entry(2, 32'd0);
        store_entry(3, 32'd0);
        store_entry(4, 32'd7);
        store_entry(5, 32'd7);
        store_entry(6, 32'd100);
        store_entry(7, WORD_MAX);
        store_entry(DEPTH - 1, 32'h5A5A_A5A5);
        store_entry(DEPTH + 4, 32'd100);
        search_for(32'd0);
        wait_idle();
        write_register(CFG_ENTRY_COUNT, 11'd8);
        set_mode(MODE_FORWARD);
        search_for(32'd0);
        search_for(32'd7);
        wait_idle();
        set_mode(MODE_BACKWARD);
        search_for(32'd0);
        search_for(32'd7);
        search_for(WORD_MIN);
        wait_idle();
        set_mode(MODE_BINARY);
        search_for(WORD_MAX);
        search_for(WORD_MIN);
        search_for(32'd3);
        wait_idle();
        set_mode(MODE_SPARE);
        search_for(32'd100);
        store_entry(2, 32'd1000);
        search_for(32'd1000);
        search_for(32'hFFFF_FFFB);

        // fill the whole table in ascending order, with runs of duplicates
        v = VALUE_MIN + 17;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == DEPTH - 1)
                v = VALUE_MAX;
            store_entry(i, v[31:0]);
            if ($urandom_range(0, 9) != 0)
                v = v + $urandom_range(1, 4_000_000);
            if (v > VALUE_MAX)
                v = VALUE_MAX;
        end
        search_for(shadow[3]);
        for (int m = 0; m < 3; m++)
        begin
            wait_idle();
            write_register(CFG_ENTRY_COUNT, COUNT_W'(DEPTH));
            set_mode(m[MODE_W-1:0]);
            search_for(shadow[$urandom_range(0, DEPTH - 1)]);
            search_for(WORD_MAX);
            search_for(WORD_MIN);
        end
        wait_idle();
        write_register(CFG_ENTRY_COUNT, 11'h7FF);
        set_mode(MODE_FORWARD);
        search_for(WORD_MAX);
        wait_idle();
        set_mode(MODE_BINARY);
        search_for(shadow[$urandom_range(0, DEPTH - 1)]);
        search_for(WORD_MIN);

        // random phases, each with its own settings
        goal = sent + RANDOM_ITEMS;
        while (sent < goal)
        begin
            wait_idle();
            r = $urandom_range(0, 99);
            if (r < 3)
                count_sel = 0;
            else if (r < 75)
                count_sel = $urandom_range(1, 16);
            else if (r < 95)
                count_sel = $urandom_range(17, 128);
            else if (r < 99)
                count_sel = $urandom_range(129, DEPTH);
            else
                count_sel = $urandom_range(DEPTH + 1, 2047);
            mode_sel = MODE_W'($urandom_range(0, 3));
            quiet = ($urandom_range(0, 9) == 0);
            len = (count_sel > 128) ? $urandom_range(3, 6) : $urandom_range(15, 50);
            if (!pressured && sent > goal - RANDOM_ITEMS + 250)
            begin
                pressured = 1'b1;
                count_sel = $urandom_range(1, 8);
                quiet     = 1'b1;
                len       = 120;
                hold_req  = 1'b1;
            end
            write_register(CFG_ENTRY_COUNT, count_sel[COUNT_W-1:0]);
            set_mode(mode_sel);
            cnt_eff = (count_sel > DEPTH) ? DEPTH : count_sel;
            for (int k = 0; k < len; k++)
            begin
                if (k < len - 1 && $urandom_range(0, 99) < 30)
                begin
                    if (cnt_eff > 0 && $urandom_range(0, 99) < 80)
                        idx = $urandom_range(0, cnt_eff - 1);
                    else
                        idx = $urandom_range(0, DEPTH - 1);
                    if ($urandom_range(0, 99) < 15)
                        key = $urandom;
                    else
                    begin
                        // keep the table ascending around the written entry
                        lo_v = (idx == 0) ? VALUE_MIN : longint'($signed(shadow[idx-1]));
                        hi_v = (idx == DEPTH - 1) ? VALUE_MAX
                                                  : longint'($signed(shadow[idx+1]));
                        if (hi_v < lo_v)
                            hi_v = lo_v;
                        v = lo_v + longint'($urandom_range(0, 32'(hi_v - lo_v)));
                        key = v[31:0];
                    end
                    store_entry(idx, key);
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (cnt_eff == 0 || r >= 90)
                        key = $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
                    else if (r < 55)
                        key = shadow[$urandom_range(0, cnt_eff - 1)];
                    else if (r < 75)
                        key = shadow[$urandom_range(0, cnt_eff - 1)]
                              + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
                    else
                        key = $urandom;
                    search_for(key);
                end
            end
        end

        quiet = 1'b0;
        wait_idle();
        repeat (2 * SETTLE) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
